// ----- sv/rcrs_pkg.sv -----
// Package for the raster corner resample and stretch block.
// Holds the sizes, register and result codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package rcrs_pkg;

	localparam int MAX_COLS    = 4096;
	localparam int SAMPLE_BITS = 24;
	localparam int COL_AW      = $clog2(MAX_COLS);
	localparam int ROW_W       = 16;
	localparam int COL_W       = 13;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 24;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX = 2'd3;

	localparam logic [1:0] KIND_CORNER = 2'd0;
	localparam logic [1:0] KIND_RIGHT  = 2'd1;
	localparam logic [1:0] KIND_BELOW  = 2'd2;
	localparam logic [1:0] KIND_DIAG   = 2'd3;

	typedef struct packed {
		logic       load;
		logic       latch_up;
		logic       latch_left;
		logic       calc;
		logic       emit;
		logic [1:0] kind;
		logic       first;
		logic       is_last;
	} rcrs_cmd_t;

	typedef struct packed {
		logic last_col;
		logic last_row;
		logic div_done;
	} rcrs_stat_t;

endpackage

`default_nettype wire

// ----- sv/rcrs_stretch.sv -----
// Bit-serial stretch divider: (x - dmin) * 255 / (dmax - dmin), saturated to 0..255.
// One quotient bit per cycle after the prepare and test steps. Uses rcrs_pkg.
`default_nettype none

module rcrs_stretch
	import rcrs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] dmin,
	input  logic signed [SAMPLE_BITS-1:0] dmax,
	output logic                          done,
	output logic [BYTE_W-1:0]             byte_val
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int NW = DW + 9;
	localparam int RW = SAMPLE_BITS + 9;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_PREP = 2'd1;
	localparam logic [1:0] D_TEST = 2'd2;
	localparam logic [1:0] D_ITER = 2'd3;

	logic [1:0]           st_q;
	logic [2:0]           cnt_q;
	logic                 done_q;
	logic signed [DW-1:0] diff_q;
	logic signed [DW-1:0] den_q;
	logic signed [NW-1:0] num_q;
	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [BYTE_W-1:0]    quo_q;
	logic signed [NW-1:0] top_w;
	logic                 zero_w;
	logic                 sat_w;
	logic                 fit_w;

	assign top_w  = NW'(den_q) <<< BYTE_W;
	assign zero_w = (den_q <= DW'(0)) || (num_q < NW'(0));
	assign sat_w  = num_q >= top_w;
	assign fit_w  = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q   <= D_PREP;
						done_q <= 1'b0;
					end
				end
				D_PREP: st_q <= D_TEST;
				D_TEST: begin
					if (zero_w || sat_w) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q  <= D_ITER;
						cnt_q <= 3'd7;
					end
				end
				D_ITER: begin
					if (cnt_q == 3'd0) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					diff_q <= DW'(x) - DW'(dmin);
					den_q  <= DW'(dmax) - DW'(dmin);
				end
			end
			D_PREP: num_q <= (NW'(diff_q) <<< BYTE_W) - NW'(diff_q);
			D_TEST: begin
				if (zero_w) begin
					quo_q <= '0;
				end else if (sat_w) begin
					quo_q <= '1;
				end else begin
					rem_q <= num_q[RW-1:0];
					dsh_q <= RW'(den_q[SAMPLE_BITS-1:0]) << (BYTE_W - 1);
				end
			end
			D_ITER: begin
				if (fit_w) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[BYTE_W-2:0], fit_w};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign byte_val = quo_q;

endmodule

`default_nettype wire

// ----- sv/rcrs_dp.sv -----
// Datapath: configuration registers, raster counters, line buffer memory,
// corner averages, stretch divider and the result register. Uses rcrs_pkg and rcrs_stretch.
`default_nettype none

module rcrs_dp
	import rcrs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  rcrs_cmd_t                     cmd,
	output rcrs_stat_t                    stat,
	output logic [ROW_W-1:0]              corner_row,
	output logic [COL_W-1:0]              corner_col,
	output logic signed [SAMPLE_BITS-1:0] corner_value,
	output logic [BYTE_W-1:0]             photo_value,
	output logic                          photo_valid,
	output logic                          last
);

	localparam int HW = SAMPLE_BITS + 1;
	localparam int QW = SAMPLE_BITS + 2;

	logic [ROW_W-1:0]              num_rows_q;
	logic [COL_W-1:0]              num_cols_q;
	logic signed [SAMPLE_BITS-1:0] data_min_q;
	logic signed [SAMPLE_BITS-1:0] data_max_q;

	logic [ROW_W-1:0]              row_cnt_q;
	logic [COL_AW-1:0]             col_cnt_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;

	logic [ROW_W-1:0]              r_q;
	logic [COL_AW-1:0]             c_q;
	logic                          lc_q;
	logic                          lr_q;
	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic signed [SAMPLE_BITS-1:0] up_q;
	logic signed [SAMPLE_BITS-1:0] ul_q;
	logic signed [SAMPLE_BITS-1:0] v0_q;
	logic signed [SAMPLE_BITS-1:0] vr_q;
	logic signed [SAMPLE_BITS-1:0] vb_q;

	logic [ROW_W-1:0]              row_q;
	logic [COL_W-1:0]              col_q;
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [BYTE_W-1:0]             photo_q;
	logic                          pvalid_q;
	logic                          last_q;

	logic [SAMPLE_BITS-1:0]        mem [MAX_COLS];
	logic [SAMPLE_BITS-1:0]        rdata_q;
	logic [COL_AW-1:0]             raddr;
	logic [COL_AW-1:0]             waddr;
	logic [SAMPLE_BITS-1:0]        wdata;
	logic                          we;

	logic [COL_W-1:0]              nc;
	logic [COL_W-1:0]              nc_m1;
	logic [ROW_W-1:0]              nr;
	logic [ROW_W-1:0]              nr_m1;
	logic [COL_AW-1:0]             c_clamp;
	logic [ROW_W-1:0]              r_clamp;

	logic signed [HW-1:0]          half_up;
	logic signed [HW-1:0]          half_left;
	logic signed [QW-1:0]          quad;
	logic                          div_done;
	logic [BYTE_W-1:0]             div_byte;
	logic                          commit;

	assign nc = (num_cols_q == '0) ? COL_W'(1) :
		((num_cols_q > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : num_cols_q);
	assign nc_m1   = nc - COL_W'(1);
	assign nr      = (num_rows_q == '0) ? ROW_W'(1) : num_rows_q;
	assign nr_m1   = nr - ROW_W'(1);
	assign c_clamp = ({1'b0, col_cnt_q} >= nc) ? nc_m1[COL_AW-1:0] : col_cnt_q;
	assign r_clamp = (row_cnt_q >= nr) ? nr_m1 : row_cnt_q;

	assign stat.last_col = lc_q;
	assign stat.last_row = lr_q;
	assign stat.div_done = div_done;

	assign commit = cmd.emit && cmd.is_last;

	rcrs_stretch u_stretch (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.x        (sample),
		.dmin     (data_min_q),
		.dmax     (data_max_q),
		.done     (div_done),
		.byte_val (div_byte)
	);

	// The line buffer is written one column late so that the diagonal cell survives.
	assign raddr = cmd.latch_up ? (c_q - COL_AW'(1)) : c_clamp;
	assign we    = (cmd.latch_left && (c_q != '0)) ||
		(cmd.emit && (cmd.kind == KIND_CORNER) && lc_q);
	assign waddr = cmd.latch_left ? (c_q - COL_AW'(1)) : c_q;
	assign wdata = cmd.latch_left ? prev_q : cur_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign half_up   = (HW'(up_q) + HW'(cur_q)) >>> 1;
	assign half_left = (HW'(prev_q) + HW'(cur_q)) >>> 1;
	assign quad      = (QW'(ul_q) + QW'(up_q) + QW'(prev_q) + QW'(cur_q)) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROW_W'(1);
			num_cols_q <= COL_W'(1);
			data_min_q <= '0;
			data_max_q <= '0;
			row_cnt_q  <= '0;
			col_cnt_q  <= '0;
			prev_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_ROWS: num_rows_q <= cfg_data[ROW_W-1:0];
					REG_NUM_COLS: num_cols_q <= cfg_data[COL_W-1:0];
					REG_DATA_MIN: data_min_q <= cfg_data[SAMPLE_BITS-1:0];
					REG_DATA_MAX: data_max_q <= cfg_data[SAMPLE_BITS-1:0];
					default: ;
				endcase
			end
			if (commit) begin
				prev_q <= cur_q;
				if (lc_q) begin
					col_cnt_q <= '0;
					row_cnt_q <= lr_q ? '0 : (r_q + ROW_W'(1));
				end else begin
					col_cnt_q <= c_q + COL_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q   <= r_clamp;
			c_q   <= c_clamp;
			lc_q  <= (c_clamp == nc_m1[COL_AW-1:0]);
			lr_q  <= (r_clamp == nr_m1);
			cur_q <= sample;
		end
		if (cmd.latch_up) begin
			up_q <= rdata_q;
		end
		if (cmd.latch_left) begin
			ul_q <= rdata_q;
		end
		if (cmd.calc) begin
			if ((r_q == '0) && (c_q == '0)) begin
				v0_q <= cur_q;
			end else if (r_q == '0) begin
				v0_q <= half_left[SAMPLE_BITS-1:0];
			end else if (c_q == '0) begin
				v0_q <= half_up[SAMPLE_BITS-1:0];
			end else begin
				v0_q <= quad[SAMPLE_BITS-1:0];
			end
			vr_q <= (r_q == '0) ? cur_q : half_up[SAMPLE_BITS-1:0];
			vb_q <= (c_q == '0) ? cur_q : half_left[SAMPLE_BITS-1:0];
		end
		if (cmd.emit) begin
			case (cmd.kind)
				KIND_CORNER: begin
					row_q <= r_q;
					col_q <= COL_W'(c_q);
					val_q <= v0_q;
				end
				KIND_RIGHT: begin
					row_q <= r_q;
					col_q <= COL_W'(c_q) + COL_W'(1);
					val_q <= vr_q;
				end
				KIND_BELOW: begin
					row_q <= r_q + ROW_W'(1);
					col_q <= COL_W'(c_q);
					val_q <= vb_q;
				end
				default: begin
					row_q <= r_q + ROW_W'(1);
					col_q <= COL_W'(c_q) + COL_W'(1);
					val_q <= cur_q;
				end
			endcase
			photo_q  <= cmd.first ? div_byte : '0;
			pvalid_q <= cmd.first;
			last_q   <= cmd.is_last;
		end
	end

	assign corner_row   = row_q;
	assign corner_col   = col_q;
	assign corner_value = val_q;
	assign photo_value  = photo_q;
	assign photo_valid  = pvalid_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- sv/rcrs_ctrl.sv -----
// Controller: sequences line buffer reads, averaging, the stretch wait and result emission.
// Drives the datapath through rcrs_cmd_t and reads rcrs_stat_t. Uses rcrs_pkg.
`default_nettype none

module rcrs_ctrl
	import rcrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  rcrs_stat_t stat,
	output rcrs_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] next_kind;
	logic       more;
	logic       slot_free;
	logic       valid_q;

	assign slot_free = !valid_q || result_ready;

	always_comb begin
		next_kind = kind_q;
		more      = 1'b0;
		case (kind_q)
			KIND_CORNER: begin
				if (stat.last_col) begin
					next_kind = KIND_RIGHT;
					more      = 1'b1;
				end else if (stat.last_row) begin
					next_kind = KIND_BELOW;
					more      = 1'b1;
				end
			end
			KIND_RIGHT: begin
				if (stat.last_row) begin
					next_kind = KIND_BELOW;
					more      = 1'b1;
				end
			end
			KIND_BELOW: begin
				if (stat.last_col) begin
					next_kind = KIND_DIAG;
					more      = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.latch_up = 1'b1;
				state_d      = S_WR;
			end
			S_WR: begin
				cmd.latch_left = 1'b1;
				state_d        = S_SUM;
			end
			S_SUM: begin
				cmd.calc = 1'b1;
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				if (stat.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = kind_q;
					cmd.first   = (kind_q == KIND_CORNER);
					cmd.is_last = !more;
					if (!more) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_CORNER;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				kind_q <= KIND_CORNER;
			end else if (cmd.emit && more) begin
				kind_q <= next_kind;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = valid_q;

endmodule

`default_nettype wire

// ----- sv/raster_corner_resample_and_stretch.sv -----
// Top level of the raster corner resample and stretch block.
// Instantiates rcrs_ctrl and rcrs_dp; uses rcrs_pkg.
//
// Cells arrive in row-major order, one per transaction, and each gives one to four
// corner results, the first of which carries the stretched byte. The first result of an
// item is loaded once the stretch divider is done, which is early when the cell lies below or above
// the stretch range or the range is empty. Each further corner is loaded as soon as the
// output slot is free. The wait is set by the eight-step bit-serial stretch divider, and the
// two line buffer reads through the single read port overlap with it. Input is ready again
// in the cycle after the last corner is loaded. The last result of an item may wait in
// the output register while the next cell is taken. The line buffer has no clearing pass
// and holds its contents across rasters.
`default_nettype none

module raster_corner_resample_and_stretch
	import rcrs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [ROW_W-1:0]              corner_row,
	output logic [COL_W-1:0]              corner_col,
	output logic signed [SAMPLE_BITS-1:0] corner_value,
	output logic [BYTE_W-1:0]             photo_value,
	output logic                          photo_valid,
	output logic                          last
);

	rcrs_cmd_t  cmd;
	rcrs_stat_t stat;

	rcrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	rcrs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.cmd          (cmd),
		.stat         (stat),
		.corner_row   (corner_row),
		.corner_col   (corner_col),
		.corner_value (corner_value),
		.photo_value  (photo_value),
		.photo_valid  (photo_valid),
		.last         (last)
	);

`ifndef SYNTHESIS
	// One cell is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("new cell taken right after a transaction");

	// A cell is not done until its final corner has been loaded.
	a_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> !sample_ready)
		else $error("input ready while corners of a cell are pending");

	// Only the first result of a cell carries the byte.
	a_photo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !photo_valid) |-> (photo_value == '0))
		else $error("stretched byte on a later result");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/raster_corner_resample_and_stretch_tb.sv -----
// Self-checking testbench for raster_corner_resample_and_stretch.
// Streams rasters of cell elevations and predicts every corner result and stretched byte.
// Depends on rcrs_pkg and the block's RTL only.

module raster_corner_resample_and_stretch_tb;
	import rcrs_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 40;

	typedef enum logic [1:0] {STIM_CELL, STIM_CFG, STIM_HOLD} stim_kind_e;

	typedef struct {
		stim_kind_e           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		int                   level;
	} stim_t;

	typedef struct packed {
		logic [ROW_W-1:0]              row;
		logic [COL_W-1:0]              col;
		logic signed [SAMPLE_BITS-1:0] value;
		logic [BYTE_W-1:0]             photo;
		logic                          pvalid;
		logic                          is_last;
	} corner_t;

	logic                          clk;
	logic                          arst_n       = 1'b0;
	logic                          cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index    = '0;
	logic [CFG_W-1:0]              cfg_data     = '0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample       = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [ROW_W-1:0]              corner_row;
	logic [COL_W-1:0]              corner_col;
	logic signed [SAMPLE_BITS-1:0] corner_value;
	logic [BYTE_W-1:0]             photo_value;
	logic                          photo_valid;
	logic                          last;

	stim_t   stim_q[$];
	corner_t corner_q[$];

	logic signed [SAMPLE_BITS-1:0] line_mem [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] prev_cell = '0;
	int unsigned                   row_pos   = 0;
	int unsigned                   col_pos   = 0;
	logic [ROW_W-1:0]              rows_cfg  = ROW_W'(1);
	logic [COL_W-1:0]              cols_cfg  = COL_W'(1);
	logic signed [SAMPLE_BITS-1:0] lo_cfg    = '0;
	logic signed [SAMPLE_BITS-1:0] hi_cfg    = '0;

	int gap          = 0;
	int settle       = 0;
	int stall        = 0;
	int rx_level     = 0;
	int mismatch_cnt = 0;
	int cycle_cnt    = 0;

	raster_corner_resample_and_stretch u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.corner_row   (corner_row),
		.corner_col   (corner_col),
		.corner_value (corner_value),
		.photo_value  (photo_value),
		.photo_valid  (photo_valid),
		.last         (last)
	);

	function automatic int idle_pct(input int level);
		case (level)
			1: return 5;
			2: return 30;
			default: return 0;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] stretch_byte(input longint x);
		longint den, q;
		den = longint'(hi_cfg) - longint'(lo_cfg);
		if (den <= 0)
			return '0;
		q = ((x - longint'(lo_cfg)) * 255) / den;
		if (q < 0)
			return '0;
		if (q > 255)
			return 8'hFF;
		return q[BYTE_W-1:0];
	endfunction

	function automatic corner_t make_corner(input int unsigned r, input int unsigned c,
			input longint v);
		corner_t k;
		k.row     = r[ROW_W-1:0];
		k.col     = c[COL_W-1:0];
		k.value   = v[SAMPLE_BITS-1:0];
		k.photo   = '0;
		k.pvalid  = 1'b0;
		k.is_last = 1'b0;
		return k;
	endfunction

	// Every corner whose cells are complete once this cell arrives, in output order.
	function automatic void predict_cell(input logic signed [SAMPLE_BITS-1:0] cur);
		int unsigned nr, nc, r, c;
		longint cur_l, up, up_left, left, cv;
		bit at_right, at_bottom;
		corner_t outs[$];
		nr = (rows_cfg == 0) ? 1 : rows_cfg;
		nc = (cols_cfg == 0) ? 1 : cols_cfg;
		if (nc > MAX_COLS)
			nc = MAX_COLS;
		if (row_pos >= nr)
			row_pos = nr - 1;
		if (col_pos >= nc)
			col_pos = nc - 1;
		r = row_pos;
		c = col_pos;
		at_right = (c == nc - 1);
		at_bottom = (r == nr - 1);
		cur_l = cur;
		left = prev_cell;
		up = 0;
		up_left = 0;
		if (r > 0) begin
			up = line_mem[c];
			if (c > 0)
				up_left = line_mem[c - 1];
		end
		if (r == 0 && c == 0)
			cv = cur_l;
		else if (r == 0)
			cv = (left + cur_l) >>> 1;
		else if (c == 0)
			cv = (up + cur_l) >>> 1;
		else
			cv = (up_left + up + left + cur_l) >>> 2;
		outs.push_back(make_corner(r, c, cv));
		if (at_right)
			outs.push_back(make_corner(r, c + 1, (r == 0) ? cur_l : (up + cur_l) >>> 1));
		if (at_bottom)
			outs.push_back(make_corner(r + 1, c, (c == 0) ? cur_l : (left + cur_l) >>> 1));
		if (at_right && at_bottom)
			outs.push_back(make_corner(r + 1, c + 1, cur_l));
		outs[0].photo = stretch_byte(cur_l);
		outs[0].pvalid = 1'b1;
		outs[$].is_last = 1'b1;
		foreach (outs[i])
			corner_q.push_back(outs[i]);
		// The line is written one column late so the diagonal cell is still there.
		if (c > 0)
			line_mem[c - 1] = prev_cell;
		if (at_right)
			line_mem[c] = cur;
		prev_cell = cur;
		if (at_right) begin
			col_pos = 0;
			row_pos = at_bottom ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		stim_t s;
		s.kind = STIM_CFG;
		s.idx = idx;
		s.data = val;
		s.level = 0;
		stim_q.push_back(s);
	endtask

	task automatic queue_setup(input int rows, input int cols, input longint lo,
			input longint hi);
		queue_cfg(REG_NUM_ROWS, CFG_W'(rows));
		queue_cfg(REG_NUM_COLS, CFG_W'(cols));
		queue_cfg(REG_DATA_MIN, CFG_W'(lo));
		queue_cfg(REG_DATA_MAX, CFG_W'(hi));
	endtask

	task automatic queue_cell(input longint v, input int level);
		stim_t s;
		s.kind = STIM_CELL;
		s.idx = '0;
		s.data = CFG_W'(v);
		s.level = level;
		stim_q.push_back(s);
	endtask

	task automatic queue_hold();
		stim_t s;
		s.kind = STIM_HOLD;
		s.idx = '0;
		s.data = '0;
		s.level = 0;
		stim_q.push_back(s);
	endtask

	function automatic longint rand24();
		logic signed [SAMPLE_BITS-1:0] v;
		v = SAMPLE_BITS'($urandom());
		return longint'(v);
	endfunction

	function automatic longint pick_sample(input longint lo, input longint hi);
		longint span;
		span = hi - lo;
		if (span < 16)
			span = 4096;
		case ($urandom_range(0, 3))
			0: return rand24();
			3: begin
				case ($urandom_range(0, 5))
					0: return -8388608;
					1: return 8388607;
					2: return lo;
					3: return hi;
					4: return 0;
					default: return -1;
				endcase
			end
			default: return lo - span / 8 + longint'($urandom_range(0, span * 5 / 4));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sender: one pending item is considered per cycle once the current transaction is done.
	always @(posedge clk) begin : drive_proc
		logic  load_now, we_now;
		int    gap_now;
		stim_t head;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			cfg_we <= 1'b0;
			gap <= 0;
			settle <= 0;
		end else begin
			load_now = 1'b0;
			we_now = 1'b0;
			gap_now = gap;
			if (sample_valid && sample_ready)
				predict_cell(sample);
			if (sample_valid && !sample_ready) begin
				load_now = 1'b1;
			end else if (gap_now > 0) begin
				gap_now--;
			end else if (stim_q.size() != 0) begin
				head = stim_q[0];
				case (head.kind)
					STIM_CELL: begin
						if (head.level != 0 && $urandom_range(0, 99) < idle_pct(head.level)) begin
							gap_now = $urandom_range(0, 18);
						end else begin
							sample <= head.data[SAMPLE_BITS-1:0];
							rx_level <= head.level;
							load_now = 1'b1;
							void'(stim_q.pop_front());
						end
					end
					STIM_CFG: begin
						if (corner_q.size() == 0 && settle >= SETTLE_CYCLES) begin
							cfg_index <= head.idx;
							cfg_data <= head.data;
							we_now = 1'b1;
							case (head.idx)
								REG_NUM_ROWS: rows_cfg = head.data[ROW_W-1:0];
								REG_NUM_COLS: cols_cfg = head.data[COL_W-1:0];
								REG_DATA_MIN: lo_cfg = head.data[SAMPLE_BITS-1:0];
								REG_DATA_MAX: hi_cfg = head.data[SAMPLE_BITS-1:0];
								default: ;
							endcase
							void'(stim_q.pop_front());
						end
					end
					default: begin
						if (corner_q.size() == 0)
							void'(stim_q.pop_front());
					end
				endcase
			end
			sample_valid <= load_now;
			cfg_we <= we_now;
			gap <= gap_now;
			if (corner_q.size() != 0 || load_now)
				settle <= 0;
			else if (settle < SETTLE_CYCLES)
				settle <= settle + 1;
		end
	end

	// Receiver: checks each accepted transaction against the oldest predicted corner.
	always @(posedge clk) begin : watch_proc
		corner_t seen, want;
		int      stall_now;
		logic    ready_now;
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall <= 0;
		end else begin
			if (result_valid && result_ready) begin
				seen = {corner_row, corner_col, corner_value, photo_value, photo_valid, last};
				if (corner_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: row %0d col %0d value %0d photo %0d/%0b last %0b",
							seen.row, seen.col, seen.value, seen.photo, seen.pvalid, seen.is_last);
				end else begin
					want = corner_q.pop_front();
					if (seen !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"mismatch: expected row %0d col %0d value %0d photo %0d/%0b ",
								"last %0b, got row %0d col %0d value %0d photo %0d/%0b last %0b"},
								want.row, want.col, want.value, want.photo, want.pvalid,
								want.is_last, seen.row, seen.col, seen.value, seen.photo,
								seen.pvalid, seen.is_last);
					end
				end
			end
			stall_now = stall;
			ready_now = 1'b1;
			if (stall_now > 0) begin
				stall_now--;
				ready_now = 1'b0;
			end else if (rx_level != 0 && $urandom_range(0, 99) < idle_pct(rx_level)) begin
				stall_now = $urandom_range(0, 18);
				ready_now = 1'b0;
			end
			result_ready <= ready_now;
			stall <= stall_now;
		end
	end

	initial begin : stim_proc
		int     rows, cols, er, n_cells, made, lvl;
		longint lo, hi;
		arst_n = 1'b0;

		// Zero sizes act as a single cell, so each cell yields all four corners.
		queue_setup(0, 0, -8388608, 8388607);
		queue_cell(-8388608, 1);
		queue_cell(8388607, 1);
		queue_cell(0, 1);
		queue_cell(-1, 1);
		// Inverted stretch range, with extreme cells feeding the averages.
		queue_setup(2, 3, 100, 50);
		queue_cell(8388607, 2);
		queue_cell(-8388608, 2);
		queue_cell(8388607, 2);
		queue_cell(-8388608, 2);
		queue_cell(8388607, 2);
		queue_cell(8388607, 2);
		// Saturating stretch, then both sizes shrink in the middle of a raster.
		queue_setup(3, 5, -1000, 1000);
		queue_cell(-5000, 1);
		queue_cell(5000, 1);
		queue_cell(-1000, 1);
		queue_cell(1000, 1);
		queue_cell(0, 1);
		queue_cell(999, 1);
		queue_cell(-999, 1);
		queue_cfg(REG_NUM_COLS, CFG_W'(2));
		queue_cfg(REG_NUM_ROWS, CFG_W'(2));
		queue_cell(123, 1);
		// Zero-width stretch range.
		queue_setup(1, 2, 77, 77);
		queue_cell(77, 0);
		queue_cell(-5, 0);

		// An oversized column count cut short within the first row, then a short closing row.
		queue_setup(65535, 8191, -100000, 100000);
		for (int i = 0; i < 6; i++)
			queue_cell(pick_sample(-100000, 100000), 1);
		queue_cfg(REG_NUM_COLS, CFG_W'(3));
		queue_cfg(REG_NUM_ROWS, CFG_W'(2));
		for (int i = 0; i < 4; i++)
			queue_cell(pick_sample(-100000, 100000), 1);

		made = 0;
		while (made < 240) begin
			if ($urandom_range(0, 7) == 0) begin
				rows = $urandom_range(1, 2);
				cols = $urandom_range(20, 60);
			end else begin
				rows = $urandom_range(0, 5);
				cols = $urandom_range(0, 9);
			end
			lo = rand24();
			case ($urandom_range(0, 3))
				0: hi = rand24();
				1: hi = lo + $urandom_range(1, 4000);
				2: hi = lo;
				default: hi = lo + $urandom_range(100000, 8000000);
			endcase
			if (hi > 8388607)
				hi = 8388607;
			lvl = $urandom_range(0, 2);
			queue_setup(rows, cols, lo, hi);
			er = (rows == 0) ? 1 : rows;
			n_cells = er * ((cols == 0) ? 1 : cols) * $urandom_range(1, 2);
			for (int i = 0; i < n_cells; i++)
				queue_cell(pick_sample(lo, hi), lvl);
			made += n_cells;
			if ($urandom_range(0, 3) == 0)
				queue_hold();
		end

		lo = rand24();
		hi = lo + $urandom_range(1, 100000);
		if (hi > 8388607)
			hi = 8388607;
		queue_setup(4, 10, lo, hi);
		for (int i = 0; i < 40; i++)
			queue_cell(pick_sample(lo, hi), 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (stim_q.size() != 0 || sample_valid || corner_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && corner_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
